[src/icm_pkg.sv]
// Shared constants and types for the iteration count color map.
`timescale 1ns / 1ps
`default_nettype none

package icm_pkg;

    // Q1.24 fraction: 24 fraction bits plus one integer bit for 1.0
    localparam int FRAC_BITS = 24;
    localparam int Q_W       = FRAC_BITS + 1;
    localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;

    // field widths
    localparam int IN_W       = 16;
    localparam int CH_W       = 8;
    localparam int SCHEME_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int COUNT_BITS_DEF = 16;

    // quotient bits resolved per divider stage
    localparam int DIV_STEPS = 5;

    // channel coefficients, pre-scaled by 2*255 (result shifted right by 25)
    localparam int K_W = 13;
    localparam logic [K_W-1:0] K2_9  = 13'd4590;
    localparam logic [K_W-1:0] K2_15 = 13'd7650;
    localparam logic [K_W-1:0] K2_85 = 13'd4335;
    localparam logic [K_W-1:0] K2_8  = 13'd4080;
    localparam logic [7:0]     GREY_K = 8'd255;
    localparam logic [K_W-1:0] CH_MAX = 13'd255;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_SCHEME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;

    localparam logic [IN_W-1:0] LIMIT_RST = 16'd256;

    localparam logic [SCHEME_W-1:0] SCHEME_COUNT = 3'd6;

    typedef enum logic [SCHEME_W-1:0] {
        SCH_BITS      = 3'd0,
        SCH_POLY      = 3'd1,
        SCH_POLY_SWAP = 3'd2,
        SCH_POLY_ALT  = 3'd3,
        SCH_GREY      = 3'd4,
        SCH_GREY_INV  = 3'd5
    } scheme_t;

endpackage

`default_nettype wire

[src/iteration_count_color_map_unit.sv]
// Top level: escape-time iteration count to RGB pixel color map.
//
// channel  dir  handshake                 payload
// s_       in   s_tvalid / s_tready       s_tdata: iter_count
// m_       out  m_tvalid / m_tready       m_tdata: red, green, blue
// cfg_     in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One pixel per clock while m_tready is high. 5 divider stages resolve 5
// quotient bits each, then 5 palette stages (multiplier chain, scaling, select).
// Synchronous active-low reset clears valid bits and the registers
// (palette 0, limit 256). Each stage holds only while it is full and the stage
// after it is stalled, so bubbles collapse and a request is never lost.
`timescale 1ns / 1ps
`default_nettype none

module iteration_count_color_map_unit #(
    parameter int COUNT_BITS = icm_pkg::COUNT_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    input  wire  [icm_pkg::IN_W-1:0]           s_tdata,   // [15:0] iter_count
    output logic                               m_tvalid,
    input  wire                                m_tready,
    output logic [3*icm_pkg::CH_W-1:0]         m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [icm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [icm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CntW = (COUNT_BITS < icm_pkg::IN_W) ? COUNT_BITS : icm_pkg::IN_W;

    logic [icm_pkg::SCHEME_W-1:0] scheme_reg;
    logic [icm_pkg::IN_W-1:0]     limit_reg;
    logic [CntW-1:0]              lim;

    logic                    div_valid, div_ready;
    logic [icm_pkg::Q_W-1:0] div_t;
    logic [icm_pkg::CH_W-1:0] red, green, blue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scheme_reg <= '0;
            limit_reg  <= icm_pkg::LIMIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                icm_pkg::CFG_SCHEME: scheme_reg <= cfg_data[icm_pkg::SCHEME_W-1:0];
                icm_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[icm_pkg::IN_W-1:0];
                default: ;
            endcase
        end
    end

    // zero limit acts as one
    assign lim = (limit_reg[CntW-1:0] == '0) ? CntW'(1) : limit_reg[CntW-1:0];

    icm_div #(
        .CNT_W (CntW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_count  (s_tdata[CntW-1:0]),
        .lim       (lim),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_t     (div_t)
    );

    icm_palette u_palette (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_t      (div_t),
        .scheme    (scheme_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

`default_nettype wire

[src/icm_div.sv]
// Pipelined restoring divider producing the Q1.24 fraction count / limit.
`timescale 1ns / 1ps
`default_nettype none

module icm_div #(
    parameter int CNT_W = icm_pkg::COUNT_BITS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        in_valid,
    output logic                       in_ready,
    input  wire  [CNT_W-1:0]           in_count,
    input  wire  [CNT_W-1:0]           lim,
    output logic                       out_valid,
    input  wire                        out_ready,
    output logic [icm_pkg::Q_W-1:0]    out_t
);

    localparam int Steps = icm_pkg::DIV_STEPS;
    localparam int QW    = icm_pkg::Q_W;
    localparam int Stg   = (QW + Steps - 1) / Steps;

    logic [Stg-1:0]   v_reg;
    logic [CNT_W-1:0] rem_reg [Stg];
    logic [QW-1:0]    q_reg   [Stg];
    logic [Stg:0]     ce;

    assign ce[Stg]   = out_ready;
    assign in_ready  = ce[0];
    assign out_valid = v_reg[Stg-1];
    assign out_t     = q_reg[Stg-1];

    for (genvar s = 0; s < Stg; s++) begin : g_stage
        logic             v_in;
        logic [CNT_W-1:0] rem_in;
        logic [QW-1:0]    q_in;
        logic [CNT_W-1:0] rem_next;
        logic [QW-1:0]    q_next;

        if (s == 0) begin : g_first
            // count saturates to the limit, so the quotient never exceeds 1.0
            assign v_in   = in_valid;
            assign rem_in = (in_count > lim) ? lim : in_count;
            assign q_in   = '0;
        end else begin : g_rest
            assign v_in   = v_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign q_in   = q_reg[s-1];
        end

        assign ce[s] = !v_reg[s] || ce[s+1];

        always_comb begin
            logic [CNT_W:0] cand;
            cand     = '0;
            rem_next = rem_in;
            q_next   = q_in;
            for (int k = 0; k < Steps; k++) begin
                if (s * Steps + k < QW) begin
                    // first step yields the integer bit, no shift
                    if (s * Steps + k == 0) begin
                        cand = {1'b0, rem_next};
                    end else begin
                        cand = {rem_next, 1'b0};
                    end
                    if (cand >= {1'b0, lim}) begin
                        cand   = cand - {1'b0, lim};
                        q_next = {q_next[QW-2:0], 1'b1};
                    end else begin
                        q_next = {q_next[QW-2:0], 1'b0};
                    end
                    rem_next = cand[CNT_W-1:0];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (ce[s]) begin
                v_reg[s] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce[s]) begin
                rem_reg[s] <= rem_next;
                q_reg[s]   <= q_next;
            end
        end
    end

endmodule

`default_nettype wire

[src/icm_palette.sv]
// Palette pipeline: polynomial products, channel scaling and scheme select.
`timescale 1ns / 1ps
`default_nettype none

module icm_palette (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire  [icm_pkg::Q_W-1:0]          in_t,
    input  wire  [icm_pkg::SCHEME_W-1:0]     scheme,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [icm_pkg::CH_W-1:0]         red,
    output logic [icm_pkg::CH_W-1:0]         green,
    output logic [icm_pkg::CH_W-1:0]         blue
);

    localparam int QW = icm_pkg::Q_W;
    localparam int FB = icm_pkg::FRAC_BITS;
    localparam int KW = icm_pkg::K_W;
    localparam int CW = icm_pkg::CH_W;
    localparam int Stg = 5;

    logic [Stg-1:0] v_reg;
    logic [Stg:0]   ce;
    icm_pkg::scheme_t sel;

    assign sel = icm_pkg::scheme_t'((scheme >= icm_pkg::SCHEME_COUNT) ?
                                    scheme - icm_pkg::SCHEME_COUNT : scheme);

    assign ce[Stg]   = out_ready;
    assign in_ready  = ce[0];
    assign out_valid = v_reg[Stg-1];

    for (genvar s = 0; s < Stg; s++) begin : g_ce
        assign ce[s] = !v_reg[s] || ce[s+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ce[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < Stg; s++) begin
                if (ce[s]) begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // stage 1: t, u = 1 - t, t^2, u^2
    logic [QW-1:0]   t1_reg, u1_reg, tt1_reg, uu1_reg;
    logic [QW-1:0]   u_in;
    logic [2*QW-1:0] m_tt, m_uu;

    assign u_in = icm_pkg::ONE_Q - in_t;
    assign m_tt = in_t * in_t;
    assign m_uu = u_in * u_in;

    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            t1_reg  <= in_t;
            u1_reg  <= u_in;
            tt1_reg <= m_tt[FB+QW-1:FB];
            uu1_reg <= m_uu[FB+QW-1:FB];
        end
    end

    // stage 2: t^3, u^3, t^2 u^2
    logic [QW-1:0]   t2_reg, u2_reg, ttt2_reg, uuu2_reg, p22_2_reg;
    logic [2*QW-1:0] m_ttt, m_uuu, m_p22;

    assign m_ttt = tt1_reg * t1_reg;
    assign m_uuu = uu1_reg * u1_reg;
    assign m_p22 = tt1_reg * uu1_reg;

    always_ff @(posedge aclk) begin
        if (ce[1]) begin
            t2_reg    <= t1_reg;
            u2_reg    <= u1_reg;
            ttt2_reg  <= m_ttt[FB+QW-1:FB];
            uuu2_reg  <= m_uuu[FB+QW-1:FB];
            p22_2_reg <= m_p22[FB+QW-1:FB];
        end
    end

    // stage 3: t^3 u, t u^3
    logic [QW-1:0]   t3_reg, u3_reg, p22_3_reg, p3_3_reg, p13_3_reg;
    logic [2*QW-1:0] m_p3, m_p13;

    assign m_p3  = ttt2_reg * u2_reg;
    assign m_p13 = uuu2_reg * t2_reg;

    always_ff @(posedge aclk) begin
        if (ce[2]) begin
            t3_reg    <= t2_reg;
            u3_reg    <= u2_reg;
            p22_3_reg <= p22_2_reg;
            p3_3_reg  <= m_p3[FB+QW-1:FB];
            p13_3_reg <= m_p13[FB+QW-1:FB];
        end
    end

    // stage 4: scale by coefficient, grey levels
    logic [KW-1:0]    red4_reg, green4_reg, blue4_reg;
    logic [CW-1:0]    grey_t4_reg, grey_u4_reg;
    logic [FB-1:0]    tlo4_reg;
    logic [QW-1:0]    red_p, blue_p;
    logic [KW-1:0]    red_k, green_k, blue_k;
    logic [QW+KW-1:0] m_red, m_green, m_blue;
    logic [QW+CW-1:0] m_gt, m_gu;
    logic             swap;

    assign swap    = (sel == icm_pkg::SCH_POLY_SWAP);
    assign red_p   = swap ? p13_3_reg : p3_3_reg;
    assign red_k   = swap ? icm_pkg::K2_85 : icm_pkg::K2_9;
    assign green_k = (sel == icm_pkg::SCH_POLY_ALT) ? icm_pkg::K2_8 : icm_pkg::K2_15;
    assign blue_p  = swap ? p3_3_reg : p13_3_reg;
    assign blue_k  = (sel == icm_pkg::SCH_POLY) ? icm_pkg::K2_85 : icm_pkg::K2_9;

    assign m_red   = red_p * red_k;
    assign m_green = p22_3_reg * green_k;
    assign m_blue  = blue_p * blue_k;
    assign m_gt    = t3_reg * icm_pkg::GREY_K;
    assign m_gu    = u3_reg * icm_pkg::GREY_K;

    always_ff @(posedge aclk) begin
        if (ce[3]) begin
            red4_reg    <= m_red[QW+KW-1:FB+1];
            green4_reg  <= m_green[QW+KW-1:FB+1];
            blue4_reg   <= m_blue[QW+KW-1:FB+1];
            grey_t4_reg <= m_gt[FB+CW-1:FB];
            grey_u4_reg <= m_gu[FB+CW-1:FB];
            tlo4_reg    <= t3_reg[FB-1:0];
        end
    end

    // stage 5: clamp and pick the palette
    logic [CW-1:0] red_next, green_next, blue_next;
    logic [CW-1:0] red_reg, green_reg, blue_reg;

    always_comb begin
        unique case (sel)
            icm_pkg::SCH_BITS: begin
                // full count wraps to black
                blue_next  = tlo4_reg[23:16];
                red_next   = tlo4_reg[15:8];
                green_next = tlo4_reg[7:0];
            end
            icm_pkg::SCH_GREY: begin
                red_next   = grey_t4_reg;
                green_next = grey_t4_reg;
                blue_next  = grey_t4_reg;
            end
            icm_pkg::SCH_GREY_INV: begin
                red_next   = grey_u4_reg;
                green_next = grey_u4_reg;
                blue_next  = grey_u4_reg;
            end
            default: begin
                red_next   = (red4_reg > icm_pkg::CH_MAX) ? '1 : red4_reg[CW-1:0];
                green_next = (green4_reg > icm_pkg::CH_MAX) ? '1 : green4_reg[CW-1:0];
                blue_next  = (blue4_reg > icm_pkg::CH_MAX) ? '1 : blue4_reg[CW-1:0];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce[4]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

`default_nettype wire
